FILE: hw/rtl/jst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jst_pkg
// Shared types and constants of the JSON structure tokenizer.
// ----------------------------------------------------------------------------
package jst_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	// grammar states held on the stack
	localparam logic [1:0] G_VALUE    = 2'd0;
	localparam logic [1:0] G_ARR_NEXT = 2'd1;
	localparam logic [1:0] G_KEY      = 2'd2;
	localparam logic [1:0] G_OBJ_NEXT = 2'd3;

	// lexer modes
	localparam logic [3:0] M_IDLE      = 4'd0;
	localparam logic [3:0] M_ARR_FRESH = 4'd1;
	localparam logic [3:0] M_OBJ_FRESH = 4'd2;
	localparam logic [3:0] M_AFTER_KEY = 4'd3;
	localparam logic [3:0] M_STRING    = 4'd4;
	localparam logic [3:0] M_KEY_STR   = 4'd5;
	localparam logic [3:0] M_NUMBER    = 4'd6;
	localparam logic [3:0] M_REAL      = 4'd7;
	localparam logic [3:0] M_KW_NULL   = 4'd8;
	localparam logic [3:0] M_KW_TRUE   = 4'd9;
	localparam logic [3:0] M_KW_FALSE  = 4'd10;

	// event kinds
	localparam logic [3:0] EV_ARR_START = 4'd0;
	localparam logic [3:0] EV_ARR_END   = 4'd1;
	localparam logic [3:0] EV_OBJ_START = 4'd2;
	localparam logic [3:0] EV_OBJ_END   = 4'd3;
	localparam logic [3:0] EV_KEY_BYTE  = 4'd4;
	localparam logic [3:0] EV_KEY_END   = 4'd5;
	localparam logic [3:0] EV_STR_BYTE  = 4'd6;
	localparam logic [3:0] EV_STR_END   = 4'd7;
	localparam logic [3:0] EV_INT       = 4'd8;
	localparam logic [3:0] EV_TRUE      = 4'd9;
	localparam logic [3:0] EV_FALSE     = 4'd10;
	localparam logic [3:0] EV_NULL      = 4'd11;
	localparam logic [3:0] EV_REAL_BYTE = 4'd12;
	localparam logic [3:0] EV_REAL_END  = 4'd13;

	// error codes
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_END      = 3'd1;
	localparam logic [2:0] ERR_UNTERM   = 3'd2;
	localparam logic [2:0] ERR_TOKEN    = 3'd3;
	localparam logic [2:0] ERR_KEY      = 3'd4;
	localparam logic [2:0] ERR_OVERFLOW = 3'd5;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} txt_t;

	typedef struct packed {
		logic [3:0]        event_kind;
		logic signed [63:0] event_value;
		logic [2:0]        error_code;
		logic              last_of_run;
	} tok_t;

	function automatic tok_t mk_tok(input logic [3:0] kind, input logic [63:0] value,
			input logic [2:0] code);
		tok_t t;
		t.event_kind = kind;
		t.event_value = value;
		t.error_code = code;
		t.last_of_run = 1'b0;
		return t;
	endfunction

	// letter p of keyword idx (0 null, 1 true, 2 false)
	function automatic logic [7:0] kw_char(input logic [1:0] idx, input logic [2:0] p);
		logic [7:0] ch;
		ch = 8'h00;
		case (idx)
			2'd0: begin
				case (p)
					3'd0: ch = 8'h6e;
					3'd1: ch = 8'h75;
					3'd2: ch = 8'h6c;
					3'd3: ch = 8'h6c;
					default: ch = 8'h00;
				endcase
			end
			2'd1: begin
				case (p)
					3'd0: ch = 8'h74;
					3'd1: ch = 8'h72;
					3'd2: ch = 8'h75;
					3'd3: ch = 8'h65;
					default: ch = 8'h00;
				endcase
			end
			2'd2: begin
				case (p)
					3'd0: ch = 8'h66;
					3'd1: ch = 8'h61;
					3'd2: ch = 8'h6c;
					3'd3: ch = 8'h73;
					3'd4: ch = 8'h65;
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

FILE: hw/rtl/json_structure_tokenizer_top.sv
`timescale 1ns / 1ps
// the first event of a byte is offered on tok in the cycle after the byte is taken
// throughput: one byte per cycle while each byte yields at most one event and tok is not
//   stalled; a byte with several events holds txt while they drain from the event buffer
// the grammar stack sits in a memory read ahead into registers (two ports: one and two entries
//   below the top, whose register holds the top itself); pushes forward into those reads
// reset: asynchronous; the stack holds one value entry, no clearing pass is needed
// ----------------------------------------------------------------------------
// json_structure_tokenizer_top
// Streaming JSON tokenizer: one text byte in, up to three token events out.
// ----------------------------------------------------------------------------
module json_structure_tokenizer_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          txt_valid,
	output logic          txt_stall,
	input  jst_pkg::txt_t txt,
	output logic          tok_valid,
	input  logic          tok_stall,
	output jst_pkg::tok_t tok
);
	import jst_pkg::*;

	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_PLUS   = 8'h2b;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_ZERO   = 8'h30;

	// stack memory, entries below the top
	logic [1:0] mem [STACK_DEPTH];
	logic [1:0] rd1_q, rd2_q;

	logic [1:0]    top_q;
	logic [CW-1:0] count_q;
	logic [3:0]    mode_q;
	logic          quote_q, esc_q, neg_q, fin_q, err_q;
	logic [63:0]   acc_q;
	logic [2:0]    kwp_q;

	tok_t       bnd_q [3];
	logic [1:0] bnd_n_q, bnd_idx_q;

	// next-state working values
	logic [7:0]    c, lc, quote;
	logic          ws, dig, key, do_idle, hit, pops, psh, kw_ok;
	logic [1:0]    top, psh_s, kidx;
	logic [CW-1:0] cnt, nxt_cnt, ra1_w, ra2_w;
	logic [3:0]    mode;
	logic          qs, esc, neg, fin, err;
	logic [63:0]   acc, sint;
	logic [2:0]    kwp, klen;
	logic [3:0]    kev;
	logic [2:0]    fcode;
	logic          we;
	logic [AW-1:0] wa, ra1, ra2;
	logic [1:0]    wd;
	tok_t          rs [3];
	logic [1:0]    nn;

	logic accept, take, last_slot, wr;

	assign take = tok_valid && !tok_stall;
	assign last_slot = (bnd_idx_q == bnd_n_q - 2'd1);
	assign tok_valid = (bnd_n_q != 2'd0);
	assign txt_stall = tok_valid && !(take && last_slot);
	assign accept = txt_valid && !txt_stall;
	assign wr = accept && we;

	always_comb begin
		tok = bnd_q[bnd_idx_q];
		tok.last_of_run = last_slot;
	end

	always_comb begin
		c = txt.text_byte;
		lc = (c >= 8'h41 && c <= 8'h5a) ? (c | 8'h20) : c;
		ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
		dig = (c >= CH_ZERO) && (c <= 8'h39);
		cnt = count_q;
		top = top_q;
		mode = mode_q;
		qs = quote_q;
		esc = esc_q;
		neg = neg_q;
		acc = acc_q;
		kwp = kwp_q;
		fin = fin_q;
		err = err_q;
		pops = 1'b0;
		psh = 1'b0;
		psh_s = G_VALUE;
		do_idle = 1'b0;
		hit = 1'b0;
		fcode = ERR_NONE;
		we = 1'b0;
		wa = '0;
		wd = top_q;
		nn = 2'd0;
		rs[0] = mk_tok(4'd0, 64'd0, ERR_NONE);
		rs[1] = mk_tok(4'd0, 64'd0, ERR_NONE);
		rs[2] = mk_tok(4'd0, 64'd0, ERR_NONE);
		key = (mode_q == M_KEY_STR);
		quote = quote_q ? CH_SQUOTE : CH_DQUOTE;
		kidx = 2'(mode_q - M_KW_NULL);
		klen = (kidx == 2'd2) ? 3'd5 : 3'd4;
		kev = (kidx == 2'd0) ? EV_NULL : (kidx == 2'd1) ? EV_TRUE : EV_FALSE;
		kw_ok = 1'b0;
		sint = neg_q ? (64'd0 - acc_q) : acc_q;

		if (!err_q && !fin_q) begin
			case (mode_q)
				M_STRING, M_KEY_STR: begin
					if (c == quote) begin
						if (esc) begin
							esc = 1'b0;
							rs[nn] = mk_tok(key ? EV_KEY_BYTE : EV_STR_BYTE, 64'(c), ERR_NONE);
							nn = nn + 2'd1;
						end else if (key) begin
							rs[nn] = mk_tok(EV_KEY_END, 64'd0, ERR_NONE);
							nn = nn + 2'd1;
							mode = M_AFTER_KEY;
						end else begin
							rs[nn] = mk_tok(EV_STR_END, 64'd0, ERR_NONE);
							nn = nn + 2'd1;
							mode = M_IDLE;
							cnt = cnt - 1'b1;
							top = rd1_q;
							pops = 1'b1;
							if (cnt == '0) fin = 1'b1;
						end
					end else if (c == CH_LF) begin
						fcode = ERR_UNTERM;
					end else begin
						esc = (c == CH_BSLASH) ? !esc : 1'b0;
						rs[nn] = mk_tok(key ? EV_KEY_BYTE : EV_STR_BYTE, 64'(c), ERR_NONE);
						nn = nn + 2'd1;
					end
				end
				M_NUMBER: begin
					if (dig) begin
						acc = (acc_q << 3) + (acc_q << 1) + 64'(c - CH_ZERO);
					end else if (c == CH_DOT || lc == 8'h65) begin
						if (neg_q && acc_q == 64'd0)
							rs[nn] = mk_tok(EV_REAL_BYTE, 64'(CH_MINUS), ERR_NONE);
						else
							rs[nn] = mk_tok(EV_INT, sint, ERR_NONE);
						nn = nn + 2'd1;
						rs[nn] = mk_tok(EV_REAL_BYTE, 64'(c), ERR_NONE);
						nn = nn + 2'd1;
						mode = M_REAL;
					end else begin
						rs[nn] = mk_tok(EV_INT, sint, ERR_NONE);
						nn = nn + 2'd1;
						mode = M_IDLE;
						cnt = cnt - 1'b1;
						top = rd1_q;
						pops = 1'b1;
						if (cnt == '0) fin = 1'b1;
						do_idle = !fin;
					end
				end
				M_REAL: begin
					if (dig || c == CH_DOT || lc == 8'h65 || c == CH_PLUS || c == CH_MINUS) begin
						rs[nn] = mk_tok(EV_REAL_BYTE, 64'(c), ERR_NONE);
						nn = nn + 2'd1;
					end else begin
						rs[nn] = mk_tok(EV_REAL_END, 64'd0, ERR_NONE);
						nn = nn + 2'd1;
						mode = M_IDLE;
						cnt = cnt - 1'b1;
						top = rd1_q;
						pops = 1'b1;
						if (cnt == '0) fin = 1'b1;
						do_idle = !fin;
					end
				end
				M_KW_NULL, M_KW_TRUE, M_KW_FALSE: begin
					kw_ok = (kwp_q < klen) && (lc == kw_char(kidx, kwp_q));
					if (kw_ok) begin
						kwp = kwp_q + 3'd1;
						if (kwp == klen) begin
							rs[nn] = mk_tok(kev, 64'd0, ERR_NONE);
							nn = nn + 2'd1;
							mode = M_IDLE;
							cnt = cnt - 1'b1;
							top = rd1_q;
							pops = 1'b1;
							if (cnt == '0) fin = 1'b1;
						end
					end else begin
						fcode = ERR_TOKEN;
					end
				end
				M_IDLE, M_ARR_FRESH, M_OBJ_FRESH, M_AFTER_KEY: do_idle = 1'b1;
				default: begin
					mode = M_IDLE;
					do_idle = 1'b1;
				end
			endcase

			// token start or structure byte between tokens
			if (do_idle && !ws) begin
				if (mode == M_AFTER_KEY) begin
					hit = 1'b1;
					if (c == CH_COLON) begin
						top = G_OBJ_NEXT;
						mode = M_IDLE;
						psh = 1'b1;
					end else begin
						fcode = ERR_TOKEN;
					end
				end else if (mode == M_ARR_FRESH && c == CH_RBRACK) begin
					// empty array: drop the value slot and the array entry
					hit = 1'b1;
					mode = M_IDLE;
					rs[nn] = mk_tok(EV_ARR_END, 64'd0, ERR_NONE);
					nn = nn + 2'd1;
					cnt = (cnt >= CW'(2)) ? cnt - CW'(2) : '0;
					top = rd2_q;
					if (cnt == '0) fin = 1'b1;
				end else if (mode == M_OBJ_FRESH && c == CH_RBRACE) begin
					hit = 1'b1;
					mode = M_IDLE;
					rs[nn] = mk_tok(EV_OBJ_END, 64'd0, ERR_NONE);
					nn = nn + 2'd1;
					cnt = cnt - 1'b1;
					top = rd1_q;
					if (cnt == '0) fin = 1'b1;
				end
				if (!hit) begin
					mode = M_IDLE;
					case (top)
						G_VALUE: begin
							if (c == CH_LBRACK) begin
								rs[nn] = mk_tok(EV_ARR_START, 64'd0, ERR_NONE);
								nn = nn + 2'd1;
								top = G_ARR_NEXT;
								psh = 1'b1;
								mode = M_ARR_FRESH;
							end else if (c == CH_LBRACE) begin
								rs[nn] = mk_tok(EV_OBJ_START, 64'd0, ERR_NONE);
								nn = nn + 2'd1;
								top = G_KEY;
								mode = M_OBJ_FRESH;
							end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
								qs = (c == CH_SQUOTE);
								esc = 1'b0;
								mode = M_STRING;
							end else if (lc == 8'h6e || lc == 8'h74 || lc == 8'h66) begin
								mode = (lc == 8'h6e) ? M_KW_NULL :
									(lc == 8'h74) ? M_KW_TRUE : M_KW_FALSE;
								kwp = 3'd1;
							end else if (c == CH_MINUS) begin
								acc = 64'd0;
								neg = 1'b1;
								mode = M_NUMBER;
							end else if (dig) begin
								acc = 64'(c - CH_ZERO);
								neg = 1'b0;
								mode = M_NUMBER;
							end else if (c == CH_DOT) begin
								acc = 64'd0;
								neg = 1'b0;
								rs[nn] = mk_tok(EV_INT, 64'd0, ERR_NONE);
								nn = nn + 2'd1;
								rs[nn] = mk_tok(EV_REAL_BYTE, 64'(c), ERR_NONE);
								nn = nn + 2'd1;
								mode = M_REAL;
							end else begin
								fcode = ERR_TOKEN;
							end
						end
						G_ARR_NEXT: begin
							if (c == CH_COMMA) begin
								psh = 1'b1;
							end else if (c == CH_RBRACK) begin
								rs[nn] = mk_tok(EV_ARR_END, 64'd0, ERR_NONE);
								nn = nn + 2'd1;
								cnt = cnt - 1'b1;
								top = pops ? rd2_q : rd1_q;
								if (cnt == '0) fin = 1'b1;
							end else begin
								fcode = ERR_TOKEN;
							end
						end
						G_KEY: begin
							if (c == CH_DQUOTE || c == CH_SQUOTE) begin
								qs = (c == CH_SQUOTE);
								esc = 1'b0;
								mode = M_KEY_STR;
							end else begin
								fcode = ERR_KEY;
							end
						end
						default: begin
							if (c == CH_COMMA) begin
								top = G_KEY;
							end else if (c == CH_RBRACE) begin
								rs[nn] = mk_tok(EV_OBJ_END, 64'd0, ERR_NONE);
								nn = nn + 2'd1;
								cnt = cnt - 1'b1;
								top = pops ? rd2_q : rd1_q;
								if (cnt == '0) fin = 1'b1;
							end else begin
								fcode = ERR_TOKEN;
							end
						end
					endcase
				end
			end

			// push: old top goes to memory, new value slot becomes the top
			if (psh) begin
				if (cnt >= CW'(STACK_DEPTH)) begin
					fcode = ERR_OVERFLOW;
				end else begin
					we = 1'b1;
					wa = AW'(cnt - 1'b1);
					wd = top;
					top = psh_s;
					cnt = cnt + 1'b1;
				end
			end

			if (fcode != ERR_NONE) begin
				if (nn != 2'd3) begin
					rs[nn] = mk_tok(4'd0, 64'd0, fcode);
					nn = nn + 2'd1;
				end
				err = 1'b1;
				mode = M_IDLE;
			end
		end

		if (txt.end_of_text) begin
			if (!err && !fin) begin
				if ((mode == M_NUMBER || mode == M_REAL) && cnt == CW'(1)) begin
					if (mode == M_NUMBER)
						rs[nn] = mk_tok(EV_INT, neg ? (64'd0 - acc) : acc, ERR_NONE);
					else
						rs[nn] = mk_tok(EV_REAL_END, 64'd0, ERR_NONE);
				end else if (mode == M_STRING || mode == M_KEY_STR) begin
					rs[nn] = mk_tok(4'd0, 64'd0, ERR_UNTERM);
				end else if (mode == M_KW_NULL || mode == M_KW_TRUE || mode == M_KW_FALSE) begin
					rs[nn] = mk_tok(4'd0, 64'd0, ERR_TOKEN);
				end else begin
					rs[nn] = mk_tok(4'd0, 64'd0, ERR_END);
				end
				if (nn != 2'd3) nn = nn + 2'd1;
			end
			cnt = CW'(1);
			top = G_VALUE;
			mode = M_IDLE;
			qs = 1'b0;
			esc = 1'b0;
			acc = 64'd0;
			neg = 1'b0;
			kwp = 3'd0;
			fin = 1'b0;
			err = 1'b0;
		end

		nxt_cnt = accept ? cnt : count_q;
		ra1_w = nxt_cnt - CW'(2);
		ra2_w = nxt_cnt - CW'(3);
		ra1 = ra1_w[AW-1:0];
		ra2 = ra2_w[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (wr) mem[wa] <= wd;
		rd1_q <= (wr && wa == ra1) ? wd : mem[ra1];
		rd2_q <= (wr && wa == ra2) ? wd : mem[ra2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= G_VALUE;
			count_q <= CW'(1);
			mode_q <= M_IDLE;
			quote_q <= 1'b0;
			esc_q <= 1'b0;
			acc_q <= 64'd0;
			neg_q <= 1'b0;
			kwp_q <= 3'd0;
			fin_q <= 1'b0;
			err_q <= 1'b0;
		end else if (accept) begin
			top_q <= top;
			count_q <= cnt;
			mode_q <= mode;
			quote_q <= qs;
			esc_q <= esc;
			acc_q <= acc;
			neg_q <= neg;
			kwp_q <= kwp;
			fin_q <= fin;
			err_q <= err;
		end
	end

	// event buffer: holds the events of one byte while they drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_n_q <= 2'd0;
			bnd_idx_q <= 2'd0;
		end else if (accept) begin
			bnd_n_q <= nn;
			bnd_idx_q <= 2'd0;
		end else if (take) begin
			if (last_slot) begin
				bnd_n_q <= 2'd0;
				bnd_idx_q <= 2'd0;
			end else begin
				bnd_idx_q <= bnd_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			bnd_q[0] <= rs[0];
			bnd_q[1] <= rs[1];
			bnd_q[2] <= rs[2];
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");
	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid |-> (bnd_idx_q < bnd_n_q))
		else $error("event slot index past fill");
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && txt.end_of_text) |=> (count_q == CW'(1) && !err_q && !fin_q
			&& mode_q == M_IDLE))
		else $error("end of text did not rearm");
`endif

endmodule

FILE: dv/tb_json_structure_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_structure_tokenizer_top
// Self-checking bench for the JSON structure tokenizer. A directed table and directed
// texts exercise structure, keywords, strings, numbers, errors and stack overflow; random
// JSON texts with noise follow. Every event is compared against a behavioral tokenizer.
// ----------------------------------------------------------------------------
module tb_json_structure_tokenizer_top;
	import jst_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic txt_valid = 1'b0;
	logic txt_stall;
	txt_t txt = '0;
	logic tok_valid;
	logic tok_stall = 1'b0;
	tok_t tok;

	json_structure_tokenizer_top i_dut (
		.clk(clk), .arst_n(arst_n), .txt_valid(txt_valid), .txt_stall(txt_stall),
		.txt(txt), .tok_valid(tok_valid), .tok_stall(tok_stall), .tok(tok)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("tb_json_structure_tokenizer_top failed");
		$finish;
	end

	// tokenizer state
	logic [1:0] gstack [STACK_DEPTH];
	int unsigned depth;
	logic [3:0] mode;
	logic sq, esc, neg, done, err;
	logic [63:0] acc;
	int unsigned kwp;
	tok_t pend [$];
	tok_t evq [$];
	int n_fail = 0, n_tok = 0, n_req = 0, n_err = 0;

	function automatic void tz_clear();
		foreach (gstack[i]) gstack[i] = G_VALUE;
		depth = 1; mode = M_IDLE; sq = 0; esc = 0; acc = '0; neg = 0; kwp = 0;
		done = 0; err = 0;
	endfunction

	function automatic void put(logic [3:0] k, logic [63:0] v, logic [2:0] c);
		tok_t t;
		if (pend.size() < 3) begin
			t.event_kind = k; t.event_value = v; t.error_code = c; t.last_of_run = 0;
			pend.push_back(t);
		end
	endfunction

	function automatic void tz_fail(logic [2:0] c);
		put(EV_ARR_START, '0, c); err = 1; mode = M_IDLE;
	endfunction

	function automatic bit is_ws(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic bit is_dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void set_top(logic [1:0] s);
		if (depth >= 1 && depth <= STACK_DEPTH) gstack[depth-1] = s;
	endfunction

	function automatic bit push(logic [1:0] s);
		if (depth >= STACK_DEPTH) begin
			tz_fail(ERR_OVERFLOW);
			return 0;
		end
		gstack[depth] = s; depth++;
		return 1;
	endfunction

	function automatic void value_done();
		mode = M_IDLE;
		if (depth > 0) depth--;
		if (depth == 0) done = 1;
	endfunction

	function automatic logic [63:0] num_val();
		return neg ? -acc : acc;
	endfunction

	function automatic void to_real(logic [7:0] c);
		if (neg && acc == 0) put(EV_REAL_BYTE, 64'(8'h2d), ERR_NONE);
		else put(EV_INT, num_val(), ERR_NONE);
		put(EV_REAL_BYTE, 64'(c), ERR_NONE);
		mode = M_REAL;
	endfunction

	function automatic void start_value(logic [7:0] c);
		logic [7:0] l;
		l = c | 8'h20;
		if (c == "[") begin
			put(EV_ARR_START, '0, ERR_NONE); set_top(G_ARR_NEXT);
			if (push(G_VALUE)) mode = M_ARR_FRESH;
		end else if (c == "{") begin
			put(EV_OBJ_START, '0, ERR_NONE); set_top(G_KEY); mode = M_OBJ_FRESH;
		end else if (c == 8'h22 || c == 8'h27) begin
			sq = (c == 8'h27); esc = 0; mode = M_STRING;
		end else if (l == "n" || l == "t" || l == "f") begin
			mode = (l == "n") ? M_KW_NULL : (l == "t") ? M_KW_TRUE : M_KW_FALSE; kwp = 1;
		end else if (c == "-") begin
			acc = 0; neg = 1; mode = M_NUMBER;
		end else if (is_dig(c)) begin
			acc = 64'(c - "0"); neg = 0; mode = M_NUMBER;
		end else if (c == ".") begin
			acc = 0; neg = 0; to_real(c);
		end else tz_fail(ERR_TOKEN);
	endfunction

	function automatic void between(logic [7:0] c);
		logic [1:0] top;
		if (is_ws(c)) return;
		if (mode == M_AFTER_KEY) begin
			if (c == ":") begin
				set_top(G_OBJ_NEXT); mode = M_IDLE; void'(push(G_VALUE));
			end else tz_fail(ERR_TOKEN);
			return;
		end
		if (mode == M_ARR_FRESH) begin
			mode = M_IDLE;
			if (c == "]") begin
				put(EV_ARR_END, '0, ERR_NONE);
				depth = depth >= 2 ? depth - 2 : 0;
				if (depth == 0) done = 1;
				return;
			end
		end else if (mode == M_OBJ_FRESH) begin
			mode = M_IDLE;
			if (c == "}") begin
				put(EV_OBJ_END, '0, ERR_NONE); value_done();
				return;
			end
		end
		mode = M_IDLE;
		if (depth == 0 || depth > STACK_DEPTH) return;
		top = gstack[depth-1];
		case (top)
			G_VALUE: start_value(c);
			G_ARR_NEXT: begin
				if (c == ",") void'(push(G_VALUE));
				else if (c == "]") begin
					put(EV_ARR_END, '0, ERR_NONE); value_done();
				end else tz_fail(ERR_TOKEN);
			end
			G_KEY: begin
				if (c == 8'h22 || c == 8'h27) begin
					sq = (c == 8'h27); esc = 0; mode = M_KEY_STR;
				end else tz_fail(ERR_KEY);
			end
			default: begin
				if (c == ",") set_top(G_KEY);
				else if (c == "}") begin
					put(EV_OBJ_END, '0, ERR_NONE); value_done();
				end else tz_fail(ERR_TOKEN);
			end
		endcase
	endfunction

	function automatic void in_string(logic [7:0] c, bit key);
		logic [7:0] q;
		q = sq ? 8'h27 : 8'h22;
		if (c == q) begin
			if (esc) begin
				esc = 0; put(key ? EV_KEY_BYTE : EV_STR_BYTE, 64'(c), ERR_NONE);
			end else if (key) begin
				put(EV_KEY_END, '0, ERR_NONE); mode = M_AFTER_KEY;
			end else begin
				put(EV_STR_END, '0, ERR_NONE); value_done();
			end
			return;
		end
		if (c == 8'h0a) begin
			tz_fail(ERR_UNTERM);
			return;
		end
		esc = (c == 8'h5c) ? !esc : 1'b0;
		put(key ? EV_KEY_BYTE : EV_STR_BYTE, 64'(c), ERR_NONE);
	endfunction

	function automatic void in_keyword(logic [7:0] c);
		logic [1:0] idx;
		logic [7:0] l, want;
		int unsigned len;
		idx = 2'(mode - M_KW_NULL);
		len = (idx == 2) ? 5 : 4;
		l = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
		case (idx)
			2'd0: want = "null" >> (8 * (3 - kwp));
			2'd1: want = "true" >> (8 * (3 - kwp));
			default: want = "false" >> (8 * (4 - kwp));
		endcase
		if (kwp < len && l == want) begin
			kwp++;
			if (kwp == len) begin
				put(idx == 0 ? EV_NULL : idx == 1 ? EV_TRUE : EV_FALSE, '0, ERR_NONE);
				value_done();
			end
		end else tz_fail(ERR_TOKEN);
	endfunction

	function automatic void tokenize(txt_t r);
		logic [7:0] c;
		c = r.text_byte;
		pend.delete();
		if (!err && !done) begin
			case (mode)
				M_STRING: in_string(c, 0);
				M_KEY_STR: in_string(c, 1);
				M_NUMBER: begin
					if (is_dig(c)) acc = acc * 10 + 64'(c - "0");
					else if (c == "." || c == "e" || c == "E") to_real(c);
					else begin
						put(EV_INT, num_val(), ERR_NONE); value_done();
						if (!done) between(c);
					end
				end
				M_REAL: begin
					if (is_dig(c) || c == "." || c == "e" || c == "E" || c == "+" || c == "-")
						put(EV_REAL_BYTE, 64'(c), ERR_NONE);
					else begin
						put(EV_REAL_END, '0, ERR_NONE); value_done();
						if (!done) between(c);
					end
				end
				M_KW_NULL, M_KW_TRUE, M_KW_FALSE: in_keyword(c);
				default: between(c);
			endcase
		end
		if (r.end_of_text) begin
			if (!err && !done) begin
				case (mode)
					M_NUMBER, M_REAL: begin
						if (depth == 1) begin
							if (mode == M_NUMBER) put(EV_INT, num_val(), ERR_NONE);
							else put(EV_REAL_END, '0, ERR_NONE);
							value_done();
						end else tz_fail(ERR_END);
					end
					M_STRING, M_KEY_STR: tz_fail(ERR_UNTERM);
					M_KW_NULL, M_KW_TRUE, M_KW_FALSE: tz_fail(ERR_TOKEN);
					default: tz_fail(ERR_END);
				endcase
			end
			tz_clear();
		end
		if (pend.size() > 0) pend[pend.size()-1].last_of_run = 1;
		foreach (pend[i]) begin
			if (pend[i].error_code != ERR_NONE) n_err++;
			evq.push_back(pend[i]);
		end
	endfunction

	// request sender; valid stays up after a request unless a gap follows
	task automatic send(logic [7:0] c, bit eot, int gap);
		txt_t r;
		if (gap > 0) begin
			txt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.text_byte = c; r.end_of_text = eot;
		txt <= r;
		txt_valid <= 1'b1;
		@(posedge clk);
		while (txt_stall) @(posedge clk);
		tokenize(r);
		n_req++;
	endtask

	task automatic send_text(string s, bit rnd);
		for (int i = 0; i < s.len(); i++)
			send(s[i], i == s.len() - 1, rnd && ($urandom_range(0, 3) == 0) ?
				$urandom_range(0, 14) : 0);
	endtask

	// event checker
	always @(posedge clk) begin
		tok_t e;
		if (arst_n && tok_valid && !tok_stall) begin
			n_tok++;
			if (evq.size() == 0) begin
				$error("event with none expected: kind %0d", tok.event_kind);
				n_fail++;
			end else begin
				e = evq.pop_front();
				if (tok.event_kind !== e.event_kind) begin
					$error("event_kind exp %0d got %0d", e.event_kind, tok.event_kind);
					n_fail++;
				end
				if (tok.event_value !== e.event_value) begin
					$error("event_value exp %0d got %0d", e.event_value, tok.event_value);
					n_fail++;
				end
				if (tok.error_code !== e.error_code) begin
					$error("error_code exp %0d got %0d", e.error_code, tok.error_code);
					n_fail++;
				end
				if (tok.last_of_run !== e.last_of_run) begin
					$error("last_of_run exp %0d got %0d", e.last_of_run, tok.last_of_run);
					n_fail++;
				end
			end
		end
	end

	// stall pattern: a random wait before each event, with quiet stretches
	bit quiet_sink = 0;
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = quiet_sink ? 0 : $urandom_range(0, 14);
			if ($urandom_range(0, 2) == 0) w = 0;
			if (w != 0) begin
				tok_stall <= 1'b1;
				repeat (w) @(posedge clk);
				tok_stall <= 1'b0;
			end
			@(posedge clk);
			while (!tok_valid) @(posedge clk);
		end
	end

	function automatic string rand_value(int lvl);
		string s, k;
		int n;
		n = $urandom_range(0, lvl > 3 ? 5 : 7);
		case (n)
			0: return $sformatf("%0d", $urandom_range(0, 99999));
			1: return $sformatf("-%0d.%0de+%0d", $urandom_range(0, 9),
				$urandom_range(0, 999), $urandom_range(0, 9));
			2: return ($urandom_range(0, 1)) ? "NuLl" : "true";
			3: return "FALSE";
			4: begin
				s = ($urandom_range(0, 1)) ? "'" : "\"";
				k = s;
				repeat ($urandom_range(0, 4)) k = {k, string'(8'($urandom_range(32, 126)))};
				if (k[k.len()-1] == 8'h5c) k = {k, "x"};
				for (int i = 1; i < k.len(); i++) if (k[i] == s[0]) k[i] = "q";
				return {k, s};
			end
			5: return $sformatf(" %0d\t", $urandom_range(0, 9));
			6: begin
				s = "[";
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++) s = {s, i ? "," : "", rand_value(lvl + 1)};
				return {s, "]"};
			end
			default: begin
				s = "{";
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++)
					s = {s, i ? ", " : "", $sformatf("\"k%0d\":", i), rand_value(lvl + 1)};
				return {s, "}"};
			end
		endcase
	endfunction

	typedef struct {
		logic [7:0] c;
		bit eot;
		bit chk;
		tok_t want;
	} row_t;

	initial begin
		row_t rows [$];
		string s, deep;
		int len;
		tz_clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: errors and extremes with events typed in
		rows = '{
			'{8'h00, 1, 1, '{EV_ARR_START, 64'sd0, ERR_TOKEN, 1'b1}},
			'{8'hff, 1, 1, '{EV_ARR_START, 64'sd0, ERR_TOKEN, 1'b1}},
			'{" ", 1, 1, '{EV_ARR_START, 64'sd0, ERR_END, 1'b1}},
			'{"[", 0, 1, '{EV_ARR_START, 64'sd0, ERR_NONE, 1'b1}},
			'{"]", 1, 1, '{EV_ARR_END, 64'sd0, ERR_NONE, 1'b1}},
			'{"{", 0, 1, '{EV_OBJ_START, 64'sd0, ERR_NONE, 1'b1}},
			'{"5", 0, 1, '{EV_ARR_START, 64'sd0, ERR_KEY, 1'b1}},
			'{"x", 1, 0, '{EV_ARR_START, 64'sd0, ERR_NONE, 1'b0}},
			'{"7", 1, 1, '{EV_INT, 64'sd7, ERR_NONE, 1'b1}},
			'{"\"", 0, 0, '{EV_ARR_START, 64'sd0, ERR_NONE, 1'b0}},
			'{8'h0a, 1, 1, '{EV_ARR_START, 64'sd0, ERR_UNTERM, 1'b1}},
			'{"t", 1, 1, '{EV_ARR_START, 64'sd0, ERR_TOKEN, 1'b1}}
		};
		foreach (rows[i]) begin
			send(rows[i].c, rows[i].eot, $urandom_range(0, 14));
			if (rows[i].chk && (pend.size() != 1 || pend[0] !== rows[i].want)) begin
				$error("directed row %0d: table disagrees with tokenizer", i);
				n_fail++;
			end
		end

		// directed texts checked by the predictor
		send_text("18446744073709551617", 0);
		send_text("-0.5E-3 ", 0);
		send_text(".25", 0);
		send_text("[-12,'a\\'b\"',nULL,True,fAlSe,{}]", 0);
		send_text("{'k':[1e5,[]],\"z\":\"\\\\\"}zz", 0);
		send_text("[1,2", 0);
		send_text("[timestamp]", 0);
		send_text("{\"a\" 1}", 0);
		deep = "";
		repeat (STACK_DEPTH + 1) deep = {deep, "["};
		send_text(deep, 0);
		deep = "";
		repeat (STACK_DEPTH - 1) deep = {deep, "["};
		for (int i = 0; i < STACK_DEPTH - 1; i++) deep = {deep, "]"};
		send_text(deep, 0);

		// hold off until the block has drained
		txt_valid <= 1'b0;
		wait (evq.size() == 0);
		repeat (4) @(posedge clk);

		// random texts: mostly well formed, some noise and truncation
		len = n_req;
		while (n_req < len + 150) begin
			s = rand_value(0);
			case ($urandom_range(0, 9))
				0: s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(0, 255));
				1: if (s.len() > 1) s = s.substr(0, s.len() - 2);
				default: ;
			endcase
			quiet_sink = ($urandom_range(0, 4) == 0);
			send_text(s, $urandom_range(0, 3) != 0);
		end
		quiet_sink = 0;
		txt_valid <= 1'b0;

		fork
			wait (evq.size() == 0);
			begin
				repeat (200000) @(posedge clk);
			end
		join_any
		disable fork;
		repeat (10) @(posedge clk);
		if (evq.size() != 0) begin
			$error("%0d expected events never arrived", evq.size());
			n_fail++;
		end
		$display("run: %0d text bytes sent, %0d events checked, %0d error events seen",
			n_req, n_tok, n_err);
		if (n_fail == 0)
			$display("tb_json_structure_tokenizer_top passed");
		else
			$display("tb_json_structure_tokenizer_top failed");
		$finish;
	end

endmodule

FILE: json_structure_tokenizer_top.f
hw/rtl/jst_pkg.sv
hw/rtl/json_structure_tokenizer_top.sv
dv/tb_json_structure_tokenizer_top.sv
